// ===== hw/rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge out of reset.
`define SHCL_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SHCL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/shcl_pkg.sv =====
// ---------------------------------------------------------------------------
// Spatial hash cell locator package
// Configuration type, register indexes, opcodes, hash primes and state codes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package shcl_pkg;

    localparam logic [26:0] PRIME_X = 27'd73856093;
    localparam logic [26:0] PRIME_Y = 27'd19349663;
    localparam logic [26:0] PRIME_Z = 27'd83492791;

    localparam logic [24:0] TABLE_MAX   = 25'd16777216;
    localparam logic [31:0] RESET_INV   = 32'd655360;
    localparam logic [24:0] RESET_TABLE = 25'd65536;

    localparam logic REG_INV_CELL_SIZE = 1'b0;
    localparam logic REG_TABLE_SIZE    = 1'b1;

    localparam logic OP_VERTEX  = 1'b0;
    localparam logic OP_ELEMENT = 1'b1;

    localparam int DIV_BITS    = 4;
    localparam int DIV_ITERS   = 64 / DIV_BITS;
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [31:0] inv_cell_size;
        logic [24:0] table_size;
    } cfg_t;

    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_MIN  = 4'b0010,
        F_MAX  = 4'b0100,
        F_PUSH = 4'b1000
    } front_state_t;

    typedef enum logic [5:0] {
        B_IDLE = 6'b000001,
        B_DIM  = 6'b000010,
        B_MUL  = 6'b000100,
        B_PREP = 6'b001000,
        B_DIV  = 6'b010000,
        B_OUT  = 6'b100000
    } back_state_t;

    function automatic logic [24:0] eff_table(input logic [24:0] t);
        logic [24:0] r;
        if (t == 25'd0)
        begin
            r = 25'd1;
        end
        else if (t > TABLE_MAX)
        begin
            r = TABLE_MAX;
        end
        else
        begin
            r = t;
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/shcl_in_if.sv =====
// ---------------------------------------------------------------------------
// Vertex input channel
// Valid/ready channel that carries one vertex item per transfer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface shcl_in_if;
    logic               valid;
    logic               ready;
    logic               opcode;
    logic [23:0]        item_id;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic               vertex_last;

    modport source (output valid, opcode, item_id, pos_x, pos_y, pos_z, vertex_last,
                    input ready);
    modport sink (input valid, opcode, item_id, pos_x, pos_y, pos_z, vertex_last,
                  output ready);
endinterface

// ===== hw/rtl/shcl_out_if.sv =====
// ---------------------------------------------------------------------------
// Bucket output channel
// Valid/ready channel that carries one bucket result per transfer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface shcl_out_if;
    logic               valid;
    logic               ready;
    logic [23:0]        bucket_index;
    logic [23:0]        owner_id;
    logic signed [31:0] cell_x;
    logic signed [31:0] cell_y;
    logic signed [31:0] cell_z;
    logic               run_last;
    logic               cells_clipped;

    modport source (output valid, bucket_index, owner_id, cell_x, cell_y, cell_z,
                    run_last, cells_clipped, input ready);
    modport sink (input valid, bucket_index, owner_id, cell_x, cell_y, cell_z,
                  run_last, cells_clipped, output ready);
endinterface

// ===== hw/rtl/shcl_front.sv =====
// ---------------------------------------------------------------------------
// Spatial hash front end
// Accepts vertices, tracks element boxes and converts box corners to cells.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module shcl_front #(
    parameter int COORD_WIDTH = 32,
    localparam int ENTRY_W = 24 + 6 * COORD_WIDTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  shcl_pkg::cfg_t      cfg,
    shcl_in_if.sink             in_ch,
    output logic                push_valid,
    input  logic                push_ready,
    output logic [ENTRY_W-1:0]  push_data
);

    localparam logic [63:0] SAT_LIM = (64'd1 << (COORD_WIDTH - 1)) - 64'd1;

    shcl_pkg::front_state_t state_reg;

    logic signed [31:0] box_min_reg [3];
    logic signed [31:0] box_max_reg [3];
    logic               box_empty_reg;
    logic signed [31:0] op_min_reg [3];
    logic signed [31:0] op_max_reg [3];
    logic [23:0]        id_reg;
    logic [31:0]        prod_reg [3];
    logic               neg_reg [3];
    logic signed [COORD_WIDTH-1:0] cmin_reg [3];

    logic signed [31:0] pos [3];
    logic signed [31:0] new_min [3];
    logic signed [31:0] new_max [3];
    logic signed [31:0] operand [3];
    logic [31:0]        mag [3];
    logic [63:0]        prod [3];
    logic signed [COORD_WIDTH-1:0] cmax [3];
    logic               accept;

    function automatic logic signed [COORD_WIDTH-1:0] sat_cell(input logic [31:0] q,
                                                               input logic neg);
        logic [63:0] qe;
        logic [63:0] r;
        qe = {32'd0, q};
        if (neg)
        begin
            if (qe > SAT_LIM + 64'd1)
            begin
                r = 64'd0 - (SAT_LIM + 64'd1);
            end
            else
            begin
                r = 64'd0 - qe;
            end
        end
        else
        begin
            r = (qe > SAT_LIM) ? SAT_LIM : qe;
        end
        return r[COORD_WIDTH-1:0];
    endfunction

    assign pos[0] = in_ch.pos_x;
    assign pos[1] = in_ch.pos_y;
    assign pos[2] = in_ch.pos_z;

    assign in_ch.ready = (state_reg == shcl_pkg::F_IDLE);
    assign accept      = in_ch.valid && in_ch.ready;
    assign push_valid  = (state_reg == shcl_pkg::F_PUSH);

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            new_min[i] = (box_empty_reg || pos[i] < box_min_reg[i]) ? pos[i] : box_min_reg[i];
            new_max[i] = (box_empty_reg || pos[i] > box_max_reg[i]) ? pos[i] : box_max_reg[i];
            operand[i] = (state_reg == shcl_pkg::F_MIN) ? op_min_reg[i] : op_max_reg[i];
            mag[i]     = operand[i][31] ? (32'd0 - $unsigned(operand[i])) : $unsigned(operand[i]);
            prod[i]    = {32'd0, mag[i]} * {32'd0, cfg.inv_cell_size};
            cmax[i]    = sat_cell(prod_reg[i], neg_reg[i]);
        end
    end

    assign push_data = {id_reg, cmin_reg[0], cmin_reg[1], cmin_reg[2], cmax[0], cmax[1], cmax[2]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= shcl_pkg::F_IDLE;
            box_empty_reg <= 1'b1;
            for (int i = 0; i < 3; i++)
            begin
                box_min_reg[i] <= 32'sd0;
                box_max_reg[i] <= 32'sd0;
            end
        end
        else
        begin
            unique case (state_reg)
                shcl_pkg::F_IDLE:
                begin
                    if (accept)
                    begin
                        if (in_ch.opcode == shcl_pkg::OP_VERTEX)
                        begin
                            state_reg <= shcl_pkg::F_MIN;
                        end
                        else
                        begin
                            for (int i = 0; i < 3; i++)
                            begin
                                box_min_reg[i] <= new_min[i];
                                box_max_reg[i] <= new_max[i];
                            end
                            if (in_ch.vertex_last)
                            begin
                                box_empty_reg <= 1'b1;
                                state_reg     <= shcl_pkg::F_MIN;
                            end
                            else
                            begin
                                box_empty_reg <= 1'b0;
                            end
                        end
                    end
                end
                shcl_pkg::F_MIN:
                begin
                    state_reg <= shcl_pkg::F_MAX;
                end
                shcl_pkg::F_MAX:
                begin
                    state_reg <= shcl_pkg::F_PUSH;
                end
                shcl_pkg::F_PUSH:
                begin
                    if (push_ready)
                    begin
                        state_reg <= shcl_pkg::F_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= shcl_pkg::F_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            id_reg <= in_ch.item_id;
            for (int i = 0; i < 3; i++)
            begin
                op_min_reg[i] <= (in_ch.opcode == shcl_pkg::OP_ELEMENT) ? new_min[i] : pos[i];
                op_max_reg[i] <= (in_ch.opcode == shcl_pkg::OP_ELEMENT) ? new_max[i] : pos[i];
            end
        end
        if (state_reg == shcl_pkg::F_MIN || state_reg == shcl_pkg::F_MAX)
        begin
            for (int i = 0; i < 3; i++)
            begin
                prod_reg[i] <= prod[i][63:32];
                neg_reg[i]  <= operand[i][31];
            end
        end
        if (state_reg == shcl_pkg::F_MAX)
        begin
            for (int i = 0; i < 3; i++)
            begin
                cmin_reg[i] <= sat_cell(prod_reg[i], neg_reg[i]);
            end
        end
    end

endmodule

// ===== hw/rtl/shcl_fifo.sv =====
// ---------------------------------------------------------------------------
// Spatial hash work queue
// Small valid/ready queue between the front end and the cell enumerator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module shcl_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hw/rtl/shcl_back.sv =====
// ---------------------------------------------------------------------------
// Spatial hash back end
// Enumerates box cells, hashes each cell and reduces it to a bucket.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module shcl_back #(
    parameter int MAX_CELLS = 64,
    parameter int COORD_WIDTH = 32,
    localparam int ENTRY_W = 24 + 6 * COORD_WIDTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  shcl_pkg::cfg_t     cfg,
    input  logic               pop_valid,
    output logic               pop_ready,
    input  logic [ENTRY_W-1:0] pop_data,
    shcl_out_if.source         out_ch
);

    localparam int CW     = COORD_WIDTH;
    localparam int CNT_W  = $clog2(MAX_CELLS + 1);
    localparam int ITER_W = $clog2(shcl_pkg::DIV_ITERS);
    localparam int PW     = CW + 28;

    shcl_pkg::back_state_t state_reg;

    logic [23:0]          id_reg;
    logic signed [CW-1:0] lo_reg [3];
    logic [CNT_W-1:0]     dim_reg [3];
    logic                 big_reg;
    logic [CNT_W-1:0]     total_reg;
    logic                 clipped_reg;
    logic [CNT_W-1:0]     cnt_reg [3];
    logic [CNT_W-1:0]     n_reg;
    logic signed [CW-1:0] cell_reg [3];
    logic [63:0]          hp_reg [3];
    logic                 neg_reg;
    logic [63:0]          dvd_reg;
    logic [23:0]          rem_reg;
    logic [ITER_W-1:0]    iter_reg;

    logic                 out_valid_reg;
    logic [23:0]          out_bucket_reg;
    logic [23:0]          out_owner_reg;
    logic [31:0]          out_cell_reg [3];
    logic                 out_last_reg;
    logic                 out_clipped_reg;

    logic signed [CW-1:0] ent_lo [3];
    logic signed [CW-1:0] ent_hi [3];
    logic [CW:0]          dim [3];
    logic [CNT_W-1:0]     dim_c [3];
    logic                 any_big;
    logic [3*CNT_W-1:0]   prod3;
    logic                 clipped;
    logic signed [CW-1:0] cur_cell [3];
    logic [26:0]          prime [3];
    logic signed [PW-1:0] hprod [3];
    logic signed [PW+63:0] hext [3];
    logic [63:0]          hash;
    logic [24:0]          tsize;
    logic [23:0]          rem_next;
    logic [63:0]          dvd_next;
    logic [24:0]          trial;
    logic [24:0]          bucket;
    logic signed [CW+31:0] cell_ext [3];
    logic                 load_out;
    logic                 run_end;

    assign prime[0] = shcl_pkg::PRIME_X;
    assign prime[1] = shcl_pkg::PRIME_Y;
    assign prime[2] = shcl_pkg::PRIME_Z;
    assign tsize    = shcl_pkg::eff_table(cfg.table_size);

    assign {ent_lo[0], ent_lo[1], ent_lo[2], ent_hi[0], ent_hi[1], ent_hi[2]} =
        pop_data[6*CW-1:0];

    assign pop_ready = (state_reg == shcl_pkg::B_IDLE);
    assign load_out  = (state_reg == shcl_pkg::B_OUT) && (!out_valid_reg || out_ch.ready);
    assign run_end   = ((n_reg + 1'b1) == total_reg);

    always_comb
    begin
        any_big = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            dim[i]   = {ent_hi[i][CW-1], ent_hi[i]} - {ent_lo[i][CW-1], ent_lo[i]}
                       + (CW+1)'(1);
            dim_c[i] = (dim[i] > (CW+1)'(MAX_CELLS)) ? CNT_W'(MAX_CELLS) : dim[i][CNT_W-1:0];
            any_big  = any_big || (dim[i] > (CW+1)'(MAX_CELLS));
            cur_cell[i] = lo_reg[i] + CW'(cnt_reg[i]);
            hprod[i] = cur_cell[i] * $signed({1'b0, prime[i]});
            hext[i]  = hprod[i];
            cell_ext[i] = cell_reg[i];
        end
        prod3   = (3*CNT_W)'(dim_reg[0]) * (3*CNT_W)'(dim_reg[1]) * (3*CNT_W)'(dim_reg[2]);
        clipped = big_reg || (prod3 > (3*CNT_W)'(MAX_CELLS));
        hash    = hp_reg[0] ^ hp_reg[1] ^ hp_reg[2];
        rem_next = rem_reg;
        dvd_next = dvd_reg;
        for (int s = 0; s < shcl_pkg::DIV_BITS; s++)
        begin
            trial    = {rem_next, dvd_next[63]};
            dvd_next = {dvd_next[62:0], 1'b0};
            rem_next = (trial >= tsize) ? 24'(trial - tsize) : trial[23:0];
        end
        bucket = (neg_reg && rem_reg != 24'd0) ? (tsize - {1'b0, rem_reg}) : {1'b0, rem_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= shcl_pkg::B_IDLE;
            out_valid_reg <= 1'b0;
            iter_reg      <= '0;
            n_reg         <= '0;
            for (int i = 0; i < 3; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                shcl_pkg::B_IDLE:
                begin
                    if (pop_valid)
                    begin
                        state_reg <= shcl_pkg::B_DIM;
                    end
                end
                shcl_pkg::B_DIM:
                begin
                    n_reg <= '0;
                    for (int i = 0; i < 3; i++)
                    begin
                        cnt_reg[i] <= '0;
                    end
                    state_reg <= shcl_pkg::B_MUL;
                end
                shcl_pkg::B_MUL:
                begin
                    state_reg <= shcl_pkg::B_PREP;
                end
                shcl_pkg::B_PREP:
                begin
                    iter_reg  <= '0;
                    state_reg <= shcl_pkg::B_DIV;
                end
                shcl_pkg::B_DIV:
                begin
                    iter_reg <= iter_reg + 1'b1;
                    if (iter_reg == ITER_W'(shcl_pkg::DIV_ITERS - 1))
                    begin
                        state_reg <= shcl_pkg::B_OUT;
                    end
                end
                shcl_pkg::B_OUT:
                begin
                    if (load_out)
                    begin
                        n_reg <= n_reg + 1'b1;
                        if (cnt_reg[2] + 1'b1 == dim_reg[2])
                        begin
                            cnt_reg[2] <= '0;
                            if (cnt_reg[1] + 1'b1 == dim_reg[1])
                            begin
                                cnt_reg[1] <= '0;
                                cnt_reg[0] <= cnt_reg[0] + 1'b1;
                            end
                            else
                            begin
                                cnt_reg[1] <= cnt_reg[1] + 1'b1;
                            end
                        end
                        else
                        begin
                            cnt_reg[2] <= cnt_reg[2] + 1'b1;
                        end
                        state_reg <= run_end ? shcl_pkg::B_IDLE : shcl_pkg::B_MUL;
                    end
                end
                default:
                begin
                    state_reg <= shcl_pkg::B_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == shcl_pkg::B_IDLE && pop_valid)
        begin
            id_reg  <= pop_data[ENTRY_W-1 -: 24];
            big_reg <= any_big;
            for (int i = 0; i < 3; i++)
            begin
                lo_reg[i]  <= ent_lo[i];
                dim_reg[i] <= dim_c[i];
            end
        end
        if (state_reg == shcl_pkg::B_DIM)
        begin
            clipped_reg <= clipped;
            total_reg   <= clipped ? CNT_W'(MAX_CELLS) : prod3[CNT_W-1:0];
        end
        if (state_reg == shcl_pkg::B_MUL)
        begin
            for (int i = 0; i < 3; i++)
            begin
                cell_reg[i] <= cur_cell[i];
                hp_reg[i]   <= hext[i][63:0];
            end
        end
        if (state_reg == shcl_pkg::B_PREP)
        begin
            neg_reg <= hash[63];
            dvd_reg <= hash[63] ? (64'd0 - hash) : hash;
            rem_reg <= 24'd0;
        end
        if (state_reg == shcl_pkg::B_DIV)
        begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
        end
        if (load_out)
        begin
            out_bucket_reg  <= bucket[23:0];
            out_owner_reg   <= id_reg;
            out_last_reg    <= run_end;
            out_clipped_reg <= clipped_reg;
            for (int i = 0; i < 3; i++)
            begin
                out_cell_reg[i] <= cell_ext[i][31:0];
            end
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.bucket_index  = out_bucket_reg;
    assign out_ch.owner_id      = out_owner_reg;
    assign out_ch.cell_x        = out_cell_reg[0];
    assign out_ch.cell_y        = out_cell_reg[1];
    assign out_ch.cell_z        = out_cell_reg[2];
    assign out_ch.run_last      = out_last_reg;
    assign out_ch.cells_clipped = out_clipped_reg;

endmodule

// ===== hw/rtl/spatial_hash_cell_locator.sv =====
// Path: a vertex passes front end states F_MIN, F_MAX and F_PUSH, then the work queue, then
// back end states B_DIM, B_MUL, B_PREP, B_DIV and B_OUT, which registers its bucket result.
// The back end remainder loop (4 quotient bits a cycle) sets throughput, one entry at a time.
// Element vertices that are not last widen the box, give no result and leave the input ready.
// Reset: rst_n clears all control state, empties the box and the queue, and
// loads the registers with their reset values.
// ---------------------------------------------------------------------------
// Spatial hash cell locator
// Top level: register port, front end, work queue and cell enumerator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module spatial_hash_cell_locator #(
    parameter int MAX_CELLS = 64,
    parameter int COORD_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    shcl_in_if.sink     in_ch,
    shcl_out_if.source  out_ch
);

    localparam int ENTRY_W = 24 + 6 * COORD_WIDTH;

    shcl_pkg::cfg_t     cfg_reg;
    logic               cfg_write;
    logic               push_valid;
    logic               push_ready;
    logic [ENTRY_W-1:0] push_data;
    logic               pop_valid;
    logic               pop_ready;
    logic [ENTRY_W-1:0] pop_data;
    logic [24:0]        table_eff;
    logic               bucket_ok;
    logic               job_taken;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == shcl_pkg::REG_TABLE_SIZE) ? {7'd0, cfg_reg.table_size}
                                                              : cfg_reg.inv_cell_size;
    assign table_eff = shcl_pkg::eff_table(cfg_reg.table_size);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.inv_cell_size <= shcl_pkg::RESET_INV;
            cfg_reg.table_size    <= shcl_pkg::RESET_TABLE;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                shcl_pkg::REG_INV_CELL_SIZE: cfg_reg.inv_cell_size <= pwdata;
                shcl_pkg::REG_TABLE_SIZE:    cfg_reg.table_size    <= pwdata[24:0];
                default:                     cfg_reg <= cfg_reg;
            endcase
        end
    end

    shcl_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_ch      (in_ch),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    shcl_fifo #(
        .WIDTH (ENTRY_W),
        .DEPTH (shcl_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    shcl_back #(
        .MAX_CELLS   (MAX_CELLS),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .out_ch    (out_ch)
    );

    assign bucket_ok = !out_ch.valid || (25'(out_ch.bucket_index) < table_eff);
    assign job_taken = in_ch.valid && in_ch.ready
                       && ((in_ch.opcode == shcl_pkg::OP_VERTEX) || in_ch.vertex_last);

    `SHCL_ASSERT_ALWAYS(a_bucket_in_table, bucket_ok, "bucket index outside the table")
    `SHCL_ASSERT_NEXT(a_busy_after_job, job_taken, !in_ch.ready, "input taken while converting")

endmodule

// ===== tb/sv/spatial_hash_cell_locator_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Spatial hash cell locator testbench
// Drives vertex and element items into the locator over valid/ready channels.
// A local model of the cell mapping, the hash and the box enumeration predicts
// every bucket result, and each received result is compared field by field.
// The register port sets several grid and table configurations between
// phases, and both channel sides idle and stall at several rates.
// ---------------------------------------------------------------------------

module spatial_hash_cell_locator_tb;

    localparam int         MAX_CELLS   = 64;
    localparam logic [2:0] ADDR_INV    = 3'(shcl_pkg::REG_INV_CELL_SIZE) << 2;
    localparam logic [2:0] ADDR_TABLE  = 3'(shcl_pkg::REG_TABLE_SIZE) << 2;
    localparam logic       OP_VERTEX   = shcl_pkg::OP_VERTEX;
    localparam logic       OP_ELEMENT  = shcl_pkg::OP_ELEMENT;
    localparam int         SETTLE      = 40;

    typedef struct {
        logic [23:0]        bucket_index;
        logic [23:0]        owner_id;
        logic signed [31:0] cell_x;
        logic signed [31:0] cell_y;
        logic signed [31:0] cell_z;
        logic               run_last;
        logic               cells_clipped;
    } bucket_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    shcl_in_if  in_ch ();
    shcl_out_if out_ch ();

    spatial_hash_cell_locator dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    bucket_t            pending_buckets[$];
    int                 errors = 0;
    int                 idle_pct = 0;
    int                 stall_pct = 0;
    logic [31:0]        model_inv;
    logic [24:0]        model_table;
    logic signed [31:0] box_lo[3];
    logic signed [31:0] box_hi[3];
    bit                 box_void;

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic logic signed [31:0] cell_of(logic signed [31:0] p);
        logic [63:0] mag;
        logic [63:0] q;
        mag = p[31] ? (64'd0 - {{32{1'b1}}, p}) : {32'd0, p};
        q = (mag * {32'd0, model_inv}) >> 32;
        if (p[31])
        begin
            if (q > 64'h8000_0000)
            begin
                q = 64'h8000_0000;
            end
            return 32'(64'd0 - q);
        end
        if (q > 64'h7FFF_FFFF)
        begin
            q = 64'h7FFF_FFFF;
        end
        return 32'(q);
    endfunction

    function automatic logic [23:0] bucket_hash(logic signed [31:0] i, logic signed [31:0] j,
                                                logic signed [31:0] k);
        logic [63:0] n;
        logic [63:0] h;
        logic [63:0] mag;
        logic [63:0] r;
        n = {39'd0, model_table};
        if (n == 64'd0)
        begin
            n = 64'd1;
        end
        if (n > 64'd16777216)
        begin
            n = 64'd16777216;
        end
        h = ({{32{i[31]}}, i} * {37'd0, shcl_pkg::PRIME_X})
          ^ ({{32{j[31]}}, j} * {37'd0, shcl_pkg::PRIME_Y})
          ^ ({{32{k[31]}}, k} * {37'd0, shcl_pkg::PRIME_Z});
        mag = h[63] ? (64'd0 - h) : h;
        r = mag % n;
        if (h[63] && r != 64'd0)
        begin
            r = n - r;
        end
        return r[23:0];
    endfunction

    function automatic void push_bucket(logic signed [31:0] cx, logic signed [31:0] cy,
                                        logic signed [31:0] cz, logic [23:0] id,
                                        logic last, logic clipped);
        bucket_t b;
        b.bucket_index  = bucket_hash(cx, cy, cz);
        b.owner_id      = id;
        b.cell_x        = cx;
        b.cell_y        = cy;
        b.cell_z        = cz;
        b.run_last      = last;
        b.cells_clipped = clipped;
        pending_buckets.insert(pending_buckets.size(), b);
    endfunction

    function automatic void predict_item(logic op, logic [23:0] id, logic signed [31:0] px,
                                         logic signed [31:0] py, logic signed [31:0] pz,
                                         logic last);
        logic signed [31:0] pos[3];
        logic signed [63:0] lo[3];
        logic [63:0]        span[3];
        logic [63:0]        total;
        logic [63:0]        count;
        logic               clipped;
        pos[0] = px;
        pos[1] = py;
        pos[2] = pz;
        if (op == OP_VERTEX)
        begin
            push_bucket(cell_of(px), cell_of(py), cell_of(pz), id, 1'b1, 1'b0);
            return;
        end
        for (int d = 0; d < 3; d++)
        begin
            if (box_void || pos[d] < box_lo[d])
            begin
                box_lo[d] = pos[d];
            end
            if (box_void || pos[d] > box_hi[d])
            begin
                box_hi[d] = pos[d];
            end
        end
        box_void = 1'b0;
        if (!last)
        begin
            return;
        end
        for (int d = 0; d < 3; d++)
        begin
            lo[d] = 64'(cell_of(box_lo[d]));
            span[d] = 64'(64'(cell_of(box_hi[d])) - lo[d]) + 64'd1;
        end
        clipped = span[0] > MAX_CELLS || span[1] > MAX_CELLS || span[2] > MAX_CELLS
               || span[0] * span[1] * span[2] > MAX_CELLS;
        total = clipped ? 64'(MAX_CELLS) : span[0] * span[1] * span[2];
        count = 0;
        for (logic [63:0] a = 0; a < span[0] && count < total; a++)
        begin
            for (logic [63:0] b = 0; b < span[1] && count < total; b++)
            begin
                for (logic [63:0] c = 0; c < span[2] && count < total; c++)
                begin
                    push_bucket(32'(lo[0] + a), 32'(lo[1] + b), 32'(lo[2] + c), id,
                                count + 1 == total, clipped);
                    count++;
                end
            end
        end
        box_void = 1'b1;
    endfunction

    always @(posedge clk)
    begin
        bucket_t e;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_buckets.size() == 0)
            begin
                $error("unexpected bucket transfer, owner_id %0h", out_ch.owner_id);
                errors++;
            end
            else
            begin
                e = pending_buckets.pop_front();
                if (out_ch.bucket_index !== e.bucket_index)
                begin
                    $error("bucket_index expected %0h actual %0h", e.bucket_index,
                           out_ch.bucket_index);
                    errors++;
                end
                if (out_ch.owner_id !== e.owner_id)
                begin
                    $error("owner_id expected %0h actual %0h", e.owner_id, out_ch.owner_id);
                    errors++;
                end
                if (out_ch.cell_x !== e.cell_x)
                begin
                    $error("cell_x expected %0d actual %0d", e.cell_x, out_ch.cell_x);
                    errors++;
                end
                if (out_ch.cell_y !== e.cell_y)
                begin
                    $error("cell_y expected %0d actual %0d", e.cell_y, out_ch.cell_y);
                    errors++;
                end
                if (out_ch.cell_z !== e.cell_z)
                begin
                    $error("cell_z expected %0d actual %0d", e.cell_z, out_ch.cell_z);
                    errors++;
                end
                if (out_ch.run_last !== e.run_last)
                begin
                    $error("run_last expected %0b actual %0b", e.run_last, out_ch.run_last);
                    errors++;
                end
                if (out_ch.cells_clipped !== e.cells_clipped)
                begin
                    $error("cells_clipped expected %0b actual %0b", e.cells_clipped,
                           out_ch.cells_clipped);
                    errors++;
                end
            end
        end
    end

    task automatic drain();
        while (pending_buckets.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic reg_write(logic [2:0] addr, logic [31:0] data);
        logic [31:0] expected;
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_INV)
        begin
            model_inv = data;
            expected  = data;
        end
        else
        begin
            model_table = data[24:0];
            expected    = {7'd0, data[24:0]};
        end
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== expected)
        begin
            $error("prdata expected %0h actual %0h", expected, prdata);
            errors++;
        end
        if (pready !== 1'b1)
        begin
            $error("pready expected %0b actual %0b", 1'b1, pready);
            errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic configure(logic [31:0] inv, logic [24:0] tsize);
        reg_write(ADDR_INV, inv);
        reg_write(ADDR_TABLE, {7'd0, tsize});
    endtask

    task automatic send_item(logic op, logic [23:0] id, logic signed [31:0] px,
                             logic signed [31:0] py, logic signed [31:0] pz, logic last);
        if ($urandom_range(99) < idle_pct)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.opcode      <= op;
        in_ch.item_id     <= id;
        in_ch.pos_x       <= px;
        in_ch.pos_y       <= py;
        in_ch.pos_z       <= pz;
        in_ch.vertex_last <= last;
        do
        begin
            @(posedge clk);
        end
        while (!in_ch.ready);
        predict_item(op, id, px, py, pz, last);
    endtask

    task automatic go_quiet();
        in_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic signed [31:0] clamp32(logic signed [63:0] v);
        if (v > 64'sh7FFF_FFFF)
        begin
            return 32'sh7FFF_FFFF;
        end
        if (v < -64'sh8000_0000)
        begin
            return 32'sh8000_0000;
        end
        return 32'(v);
    endfunction

    task automatic test_vertex_extremes();
        send_item(OP_VERTEX, 24'h000000, 32'sd0, 32'sd0, 32'sd0, 1'b0);
        send_item(OP_VERTEX, 24'hFFFFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1);
        send_item(OP_VERTEX, 24'h123456, 32'sh8000_0000, 32'sh7FFF_FFFF, -32'sd1, 1'b0);
        send_item(OP_VERTEX, 24'h00ABCD, -32'sd6553, 32'sd6554, 32'sd1, 1'b1);
        go_quiet();
    endtask

    task automatic test_register_extremes();
        configure(32'd0, 25'd65536);
        send_item(OP_VERTEX, 24'h000001, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd12345, 1'b0);
        go_quiet();
        configure(32'hFFFF_FFFF, 25'd0);
        send_item(OP_VERTEX, 24'h000002, 32'sh7FFF_FFFF, 32'sh8000_0000, -32'sd3, 1'b1);
        go_quiet();
        configure(32'hFFFF_FFFF, 25'h1FF_FFFF);
        send_item(OP_VERTEX, 24'h000003, 32'sh8000_0000, 32'sh1234_5678, 32'sh7FFF_FFFF, 1'b0);
        go_quiet();
        configure(32'd1, 25'd1);
        send_item(OP_VERTEX, 24'h000004, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0, 1'b0);
        go_quiet();
        configure(32'h0080_0000, shcl_pkg::TABLE_MAX);
        send_item(OP_VERTEX, 24'h000005, 32'sh7FFF_FFFF, -32'sh0123_4567, 32'sh0765_4321, 1'b0);
        go_quiet();
        configure(shcl_pkg::RESET_INV, shcl_pkg::RESET_TABLE);
    endtask

    task automatic test_elements();
        send_item(OP_ELEMENT, 24'h100000, 32'sd70000, -32'sd70000, 32'sd0, 1'b1);
        send_item(OP_ELEMENT, 24'h100001, 32'sd100, 32'sd100, 32'sd100, 1'b0);
        send_item(OP_ELEMENT, 24'h100001, 32'sd7000, 32'sd200, 32'sd50, 1'b0);
        send_item(OP_VERTEX, 24'h200001, 32'sd900000, 32'sd900000, 32'sd900000, 1'b1);
        send_item(OP_ELEMENT, 24'h100001, 32'sd300, 32'sd7000, 32'sd60, 1'b0);
        send_item(OP_ELEMENT, 24'h100002, 32'sd400, 32'sd300, 32'sd70, 1'b1);
        send_item(OP_ELEMENT, 24'h100003, -32'sd6000, -32'sd6000, -32'sd6000, 1'b0);
        send_item(OP_ELEMENT, 24'h100003, 32'sd6000, 32'sd6000, 32'sd6000, 1'b1);
        send_item(OP_ELEMENT, 24'h100004, 32'sd0, 32'sd0, 32'sd0, 1'b0);
        send_item(OP_ELEMENT, 24'h100004, 32'sd26000, 32'sd26000, 32'sd26000, 1'b1);
        send_item(OP_ELEMENT, 24'h100005, 32'sd0, 32'sd0, 32'sd0, 1'b0);
        send_item(OP_ELEMENT, 24'h100005, 32'sd33000, 32'sd0, 32'sd0, 1'b1);
        send_item(OP_ELEMENT, 24'h100006, 32'sh8000_0000, 32'sd0, 32'sd0, 1'b0);
        send_item(OP_ELEMENT, 24'h100006, 32'sh7FFF_FFFF, 32'sd6600, 32'sd0, 1'b1);
        go_quiet();
    endtask

    task automatic test_paced();
        for (int n = 0; n < 8; n++)
        begin
            send_item(OP_VERTEX, 24'($urandom), $signed($urandom), $signed($urandom),
                      $signed($urandom), 1'($urandom));
            go_quiet();
            drain();
        end
    endtask

    task automatic random_traffic(int count);
        int                 sent;
        int                 nv;
        int                 reach;
        logic [63:0]        edge_raw;
        logic [63:0]        span;
        logic signed [31:0] base[3];
        logic signed [31:0] p[3];
        logic [23:0]        id;
        sent = 0;
        edge_raw = (model_inv == 0) ? 64'd65536 : (64'h1_0000_0000 / model_inv);
        if (edge_raw > 64'h4000_0000)
        begin
            edge_raw = 64'h4000_0000;
        end
        while (sent < count)
        begin
            if ($urandom_range(99) < 50)
            begin
                for (int d = 0; d < 3; d++)
                begin
                    p[d] = ($urandom_range(1) == 1) ? $signed($urandom)
                         : $signed($urandom_range(0, 2097152)) - 32'sd1048576;
                end
                send_item(OP_VERTEX, 24'($urandom), p[0], p[1], p[2], 1'($urandom));
                sent++;
            end
            else
            begin
                nv = ($urandom_range(99) < 70) ? 4 : $urandom_range(1, 5);
                reach = ($urandom_range(99) < 90) ? $urandom_range(0, 3) : 8;
                span = edge_raw * reach;
                if (span > 64'hFFFF_FFFF)
                begin
                    span = 64'hFFFF_FFFF;
                end
                id = 24'($urandom);
                for (int d = 0; d < 3; d++)
                begin
                    base[d] = $signed($urandom);
                end
                for (int v = 0; v < nv; v++)
                begin
                    if ($urandom_range(99) < 8)
                    begin
                        send_item(OP_VERTEX, 24'($urandom), $signed($urandom),
                                  $signed($urandom), $signed($urandom), 1'($urandom));
                        sent++;
                    end
                    for (int d = 0; d < 3; d++)
                    begin
                        p[d] = clamp32(64'(base[d]) + 64'($urandom_range(0, 32'(span))));
                    end
                    send_item(OP_ELEMENT, ($urandom_range(3) == 0) ? 24'($urandom) : id,
                              p[0], p[1], p[2], v == nv - 1);
                    sent++;
                end
            end
        end
        go_quiet();
    endtask

    task automatic test_random_phase(int idle, int stall, logic [31:0] inv,
                                     logic [24:0] tsize, int count);
        configure(inv, tsize);
        idle_pct  = idle;
        stall_pct = stall;
        random_traffic(count);
        drain();
    endtask

    initial
    begin
        rst_n             = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        in_ch.valid       = 1'b0;
        in_ch.opcode      = OP_VERTEX;
        in_ch.item_id     = '0;
        in_ch.pos_x       = '0;
        in_ch.pos_y       = '0;
        in_ch.pos_z       = '0;
        in_ch.vertex_last = 1'b0;
        out_ch.ready      = 1'b0;
        model_inv         = shcl_pkg::RESET_INV;
        model_table       = shcl_pkg::RESET_TABLE;
        box_void          = 1'b1;
        for (int d = 0; d < 3; d++)
        begin
            box_lo[d] = '0;
            box_hi[d] = '0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_vertex_extremes();
        test_register_extremes();
        stall_pct = 30;
        test_elements();
        test_paced();
        test_random_phase(0, 0, shcl_pkg::RESET_INV, shcl_pkg::RESET_TABLE, 110);
        test_random_phase(48, 0, 32'hFFFF_FFFF, shcl_pkg::TABLE_MAX, 110);
        test_random_phase(0, 48, 32'd1, 25'h1FF_FFFF, 110);
        test_random_phase(17, 17, 32'h0001_0000 + ($urandom & 32'h00FF_FFFF),
                          25'($urandom_range(1, 16777216)), 110);
        drain();
        if (errors == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial
    begin
        #100_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
